@@ src/gln_pkg.sv @@
// package: shared types and character constants of the g-code line normalizer
`default_nettype none

package gln_pkg;

  localparam int unsigned MAX_LINE_LEN_DEF = 256;

  // line status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_NESTED   = 2'd2,
    ST_UNCLOSED = 2'd3
  } status_t;

  // characters that steer the scan
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] UPPER_LO  = 8'd64;
  localparam logic [7:0] UPPER_HI  = 8'd91;
  localparam logic [7:0] CH_UP_A   = UPPER_LO + 8'd1;
  localparam logic [7:0] CH_UP_Z   = UPPER_HI - 8'd1;
  localparam logic [7:0] CASE_OFS  = 8'd32;

  // per-line scan flags, the counter is kept apart since its width is a parameter
  typedef struct packed {
    logic    paren;
    logic    rest;
    logic    slash;
    status_t err;
  } line_state_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_valid;
    logic       done_res;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

@@ src/gln_if.sv @@
// interfaces: byte input channel and result channel
`default_nettype none

interface gln_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface gln_out_if import gln_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_valid;
  logic       done_res;
  status_t    status;

  modport source (output valid, output out_char, output out_valid, output done_res,
                  output status, input ready);
  modport sink   (input valid, input out_char, input out_valid, input done_res,
                  input status, output ready);
endinterface

`default_nettype wire

@@ src/gln_step.sv @@
// next-state and result logic for one line byte or line end
`default_nettype none

module gln_step import gln_pkg::*; #(
  parameter int unsigned MAX_LINE_LEN = MAX_LINE_LEN_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_LINE_LEN)
) (
  input  wire line_state_t      st,
  input  wire logic [CNT_W-1:0] cnt,
  input  wire logic [7:0]       ch,
  input  wire logic             line_end,
  output line_state_t           st_nxt,
  output logic [CNT_W-1:0]      cnt_nxt,
  output result_t               res
);

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LINE_LEN - 1);

  logic       rest;
  logic       append;
  logic [7:0] oc;

  always_comb begin
    st_nxt  = st;
    cnt_nxt = cnt;
    res     = '0;
    rest    = 1'b0;
    append  = 1'b0;
    oc      = ch;
    if (line_end) begin
      res.done_res = 1'b1;
      res.status   = (st.err == ST_OK && st.paren) ? ST_UNCLOSED : st.err;
      st_nxt       = '0;
      cnt_nxt      = '0;
    end else if (st.err != ST_OK) begin
      res.status = st.err;
    end else begin
      st_nxt.slash = (ch == CH_SLASH);
      if (cnt >= CNT_LIMIT) begin
        st_nxt.err = ST_TOO_LONG;
        res.status = ST_TOO_LONG;
      end else begin
        rest = st.rest || (!st.paren && (ch == CH_SEMI || (ch == CH_SLASH && st.slash)));
        st_nxt.rest = rest;
        if (rest) begin
          append = 1'b1;
        end else if (st.paren) begin
          if (ch == CH_RPAR) begin
            st_nxt.paren = 1'b0;
            append       = 1'b1;
          end else if (ch == CH_LPAR) begin
            st_nxt.err = ST_NESTED;
          end else begin
            append = 1'b1;
          end
        end else if (ch inside {CH_SPACE, CH_TAB, CH_CR}) begin
          append = 1'b0;
        end else if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
          oc     = ch + CASE_OFS;
          append = 1'b1;
        end else if (ch == CH_LPAR) begin
          st_nxt.paren = 1'b1;
          append       = 1'b1;
        end else begin
          append = 1'b1;
        end
        if (append) begin
          cnt_nxt       = cnt + CNT_W'(1);
          res.out_char  = oc;
          res.out_valid = 1'b1;
        end
        res.status = st_nxt.err;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/gcode_line_normalizer.sv @@
// top level: g-code line normalizer with input and result register stages
`default_nettype none

// Normalizes a G-code line one byte per transfer and answers every input
// transfer with exactly one result transfer, in order. Outside comments it
// drops space, tab and CR, lowers A-Z and copies everything else; "(...)"
// and rest-of-line comments opened by ';' or "//" pass literally. A nested
// '(' or a line reaching MAX_LINE_LEN-1 appended bytes raises an error that
// silences output until the line-end transfer, which reports the first error
// (or an unclosed parenthesis comment) and clears the line state. Throughput
// is one byte per clock while out_res.ready does not stall the result; each
// item passes the input register and then the result register, with the
// scan flags and the byte counter updated as an item moves between them.
// in_ch.ready follows out_res.ready combinationally through both stages, so a
// stalled result still leaves room for one more byte in the input register.

module gcode_line_normalizer import gln_pkg::*; #(
  parameter int unsigned MAX_LINE_LEN = MAX_LINE_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gln_in_if.sink     in_ch,
  gln_out_if.source  out_res
);

  localparam int unsigned CNT_W = $clog2(MAX_LINE_LEN);

  // input register stage
  logic             s1_valid_r;
  logic [7:0]       s1_ch_r;
  logic             s1_end_r;

  // line state, advanced when an item leaves the input register
  line_state_t      st_r;
  line_state_t      st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // result register stage
  logic             s2_valid_r;
  result_t          s2_res_r;
  result_t          res;

  logic             s2_load;
  logic             s1_adv;
  logic             s1_load;

  // result register can take a new value when empty or being drained
  assign s2_load = !s2_valid_r || out_res.ready;
  assign s1_adv  = s1_valid_r && s2_load;
  assign s1_load = !s1_valid_r || s2_load;

  assign in_ch.ready = s1_load;

  gln_step #(
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_step (
    .st       (st_r),
    .cnt      (cnt_r),
    .ch       (s1_ch_r),
    .line_end (s1_end_r),
    .st_nxt   (st_nxt),
    .cnt_nxt  (cnt_nxt),
    .res      (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_ch.valid;
    end
    if (s1_load && in_ch.valid) begin
      s1_ch_r  <= in_ch.ch;
      s1_end_r <= in_ch.line_end;
    end
  end

  // line state follows each item as it is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= '0;
    end else if (s1_adv) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s1_adv) begin
      s2_res_r <= res;
    end
  end

  assign out_res.valid     = s2_valid_r;
  assign out_res.out_char  = s2_res_r.out_char;
  assign out_res.out_valid = s2_res_r.out_valid;
  assign out_res.done_res  = s2_res_r.done_res;
  assign out_res.status    = s2_res_r.status;

endmodule

`default_nettype wire

@@ src/gln_checker.sv @@
// checker: port-level properties of the g-code line normalizer, bound to the top
`default_nettype none

module gln_checker import gln_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_hs_valid,
  input wire logic       out_hs_ready,
  input wire logic [7:0] out_char,
  input wire logic       out_valid,
  input wire logic       done_res,
  input wire logic [1:0] status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs_valid && !out_hs_ready |=> out_hs_valid && $stable(out_char) &&
      $stable(out_valid) && $stable(done_res) && $stable(status))
    else $error("result changed while stalled");

  // no byte means a zero byte
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs_valid && !out_valid |-> out_char == 8'd0)
    else $error("out_char nonzero without out_valid");

  // line-end result carries no byte
  a_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs_valid && done_res |-> !out_valid)
    else $error("line-end result appends a byte");

  // a byte is appended only on an error-free line
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs_valid && out_valid |-> status == ST_OK)
    else $error("byte appended after error");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_hs_valid)
    else $error("result valid right after reset");

endmodule

bind gcode_line_normalizer gln_checker u_gln_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_hs_valid (out_res.valid),
  .out_hs_ready (out_res.ready),
  .out_char     (out_res.out_char),
  .out_valid    (out_res.out_valid),
  .done_res     (out_res.done_res),
  .status       (out_res.status)
);

`default_nettype wire

@@ tb/sv/tb_gcode_line_normalizer.sv @@
// testbench: g-code line normalizer checked against a line-state predictor and a result scoreboard
`default_nettype none

module tb_gcode_line_normalizer;
  timeunit 1ns;
  timeprecision 1ps;
  import gln_pkg::*;

  localparam int unsigned MAX_LEN = MAX_LINE_LEN_DEF;
  localparam int RAND_ITEMS  = 2000;  // rough size of the random stimulus
  localparam int LONG_EVERY  = 650;   // spacing of the overlong lines
  localparam int QUIET_ITEMS = 250;   // last stretch of the run runs without idling
  localparam int HOLD_AFTER  = 700;   // input transfers before the long receiver hold-off
  localparam int HOLD_CYCLES = 160;
  localparam int TAIL_CYCLES = 20;    // drain time after the last expected result
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } line_item_t;

  logic clk = 1'b0;
  logic rst_n;

  gln_in_if  in_ch ();
  gln_out_if out_res ();

  gcode_line_normalizer #(
    .MAX_LINE_LEN(MAX_LEN)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_res(out_res)
  );

  always #5 clk = ~clk;

  // raw bytes waiting to be offered, front entry is the one on the bus
  line_item_t raw_line_bytes[$];
  // normalized results predicted for accepted bytes, oldest first
  result_t    predicted_results[$];

  // predictor copy of the per-line scan state
  logic        ln_paren = 1'b0;
  logic        ln_rest  = 1'b0;
  logic        ln_slash = 1'b0;
  int unsigned ln_count = 0;
  status_t     ln_err   = ST_OK;

  int accepted_cnt = 0;
  int sent_cnt     = 0;
  int results_cnt  = 0;
  int mismatch_cnt = 0;
  int lines_done   = 0;
  int status_seen[4] = '{default: 0};
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int hold_stalls  = 0;

  // ---------------------------------------------------------------------------
  // predictor: one raw byte or line end in, one normalized result out
  // ---------------------------------------------------------------------------
  function automatic result_t normalize_line_byte(input logic [7:0] c, input logic le);
    result_t    r;
    logic       was_slash;
    logic       append;
    logic [7:0] oc;
    r         = '0;
    r.status  = ST_OK;
    append    = 1'b0;
    oc        = c;
    if (le) begin
      // line end: report the first error, or an open paren comment, then clear
      r.done_res = 1'b1;
      r.status   = (ln_err == ST_OK && ln_paren) ? ST_UNCLOSED : ln_err;
      status_seen[r.status]++;
      lines_done++;
      ln_paren = 1'b0;
      ln_rest  = 1'b0;
      ln_slash = 1'b0;
      ln_count = 0;
      ln_err   = ST_OK;
    end else if (ln_err != ST_OK) begin
      // after an error the line stays silent and frozen
      r.status = ln_err;
    end else begin
      was_slash = ln_slash;
      ln_slash  = (c == CH_SLASH);
      if (ln_count >= MAX_LEN - 1) begin
        // length check comes first, even for bytes that would be dropped
        ln_err   = ST_TOO_LONG;
        r.status = ln_err;
      end else begin
        if (!ln_paren && (c == CH_SEMI || (c == CH_SLASH && was_slash))) begin
          ln_rest = 1'b1;
        end
        if (ln_rest) begin
          append = 1'b1;
        end else if (ln_paren) begin
          if (c == CH_RPAR) begin
            ln_paren = 1'b0;
            append   = 1'b1;
          end else if (c == CH_LPAR) begin
            ln_err = ST_NESTED;
          end else begin
            append = 1'b1;
          end
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
          append = 1'b0;
        end else if (c > UPPER_LO && c < UPPER_HI) begin
          oc     = c + CASE_OFS;
          append = 1'b1;
        end else if (c == CH_LPAR) begin
          ln_paren = 1'b1;
          append   = 1'b1;
        end else begin
          append = 1'b1;
        end
        if (append) begin
          ln_count++;
          r.out_char  = oc;
          r.out_valid = 1'b1;
        end
        r.status = ln_err;
      end
    end
    return r;
  endfunction

  // idle chance in percent: varies by phase, none in the final stretch
  function automatic int idle_pct();
    if (raw_line_bytes.size() < QUIET_ITEMS) begin
      return 0;
    end
    case ((accepted_cnt / 150) % 3)
      0:       return 0;
      1:       return 6;
      default: return 25;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < MAX_REPORTS) begin
      $display("[%0t] result %0d: %s", $time, results_cnt, what);
    end
    mismatch_cnt++;
  endtask

  task automatic push_byte(input logic [7:0] c);
    line_item_t item;
    item           = '0;
    item.ch        = c;
    item.line_end  = 1'b0;
    raw_line_bytes = {raw_line_bytes, item};
  endtask

  // the byte lane carries random junk on a line end, it must be ignored
  task automatic push_end();
    line_item_t item;
    item           = '0;
    item.ch        = 8'($urandom_range(0, 255));
    item.line_end  = 1'b1;
    raw_line_bytes = {raw_line_bytes, item};
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) begin
      push_byte(s[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the front byte at the falling edge, holds it until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    bit taken;
    taken = (sent_cnt != accepted_cnt);
    if (taken) begin
      raw_line_bytes.delete(0);
      sent_cnt = accepted_cnt;
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (taken || !in_ch.valid) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (raw_line_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (hold_left == 0 && $urandom_range(0, 99) < idle_pct()) begin
        // idle burst that starts with this one
        send_gap = $urandom_range(0, 17);
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid    <= 1'b1;
        in_ch.ch       <= raw_line_bytes[0].ch;
        in_ch.line_end <= raw_line_bytes[0].line_end;
      end
    end
  end

  // receiver ready: random stall bursts plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_res.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_res.ready <= 1'b0;
    end else if ($urandom_range(0, 199) < idle_pct()) begin
      recv_gap = $urandom_range(0, 17);
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  // one long hold-off of the receiver while the sender keeps pushing bytes
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check the result transfer first, then predict the input transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_res.valid && out_res.ready) begin
        got.out_char  = out_res.out_char;
        got.out_valid = out_res.out_valid;
        got.done_res  = out_res.done_res;
        got.status    = out_res.status;
        if (predicted_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = predicted_results.pop_front();
          if (got.out_char !== want.out_char) begin
            report_mismatch($sformatf("out_char %h, expected %h", got.out_char, want.out_char));
          end
          if (got.out_valid !== want.out_valid) begin
            report_mismatch($sformatf("out_valid %b, expected %b",
                                      got.out_valid, want.out_valid));
          end
          if (got.done_res !== want.done_res) begin
            report_mismatch($sformatf("done_res %b, expected %b", got.done_res, want.done_res));
          end
          if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          end
        end
        results_cnt++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_results = {predicted_results,
                             normalize_line_byte(in_ch.ch, in_ch.line_end)};
        accepted_cnt <= accepted_cnt + 1;
      end
      // input side backed up by the stalled receiver
      if (hold_left > 0 && in_ch.valid && !in_ch.ready) begin
        hold_stalls++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    string      letters  = "GMXYZFSTIJKNP";
    string      specials = "()();//  \t\rAZaz@[{";
    string      blanks   = " \t\r";
    logic [7:0] c;
    int         next_long;
    int         kind;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.ch       = 8'h00;
    in_ch.line_end = 1'b0;
    out_res.ready  = 1'b0;

    // directed: case folding edges, blanks, byte extremes, slash lookahead
    // across a blank, comment markers inside a paren comment, then "//"
    push_text("AZ \t\r@[");
    push_byte(8'h60);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("/ /(//;)//");
    push_end();
    // semicolon comment keeps a '(' literal
    push_text(";(");
    push_end();
    // nested paren, then a byte that must stay silent
    push_text("((B");
    push_end();
    // paren comment left open at line end
    push_text("(");
    push_end();
    // empty line
    push_end();

    next_long = raw_line_bytes.size() + 300;
    while (raw_line_bytes.size() < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (raw_line_bytes.size() >= next_long) begin
        // overlong line, sometimes all inside a rest comment
        next_long += LONG_EVERY;
        if ($urandom_range(0, 2) == 0) begin
          push_byte(CH_SEMI);
        end
        repeat ($urandom_range(252, 270)) begin
          if ($urandom_range(0, 29) == 0) begin
            c = blanks[$urandom_range(0, 2)];
          end else if ($urandom_range(0, 1) == 0) begin
            c = letters[$urandom_range(0, letters.len() - 1)];
          end else begin
            c = 8'("0" + $urandom_range(0, 9));
          end
          push_byte(c);
        end
        push_end();
      end else if (kind < 72) begin
        // well-formed g-code words with mixed case and blanks
        repeat ($urandom_range(1, 5)) begin
          c = letters[$urandom_range(0, letters.len() - 1)];
          if ($urandom_range(0, 1) == 0) begin
            c = c + CASE_OFS;
          end
          push_byte(c);
          if ($urandom_range(0, 3) == 0) begin
            push_byte("-");
          end
          repeat ($urandom_range(1, 4)) push_byte(8'("0" + $urandom_range(0, 9)));
          if ($urandom_range(0, 2) == 0) begin
            push_byte(".");
            repeat ($urandom_range(1, 3)) push_byte(8'("0" + $urandom_range(0, 9)));
          end
          repeat ($urandom_range(0, 2)) push_byte(blanks[$urandom_range(0, 2)]);
        end
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
          // paren comment of printable text, now and then left open
          push_byte(CH_LPAR);
          repeat ($urandom_range(0, 12)) push_byte(8'($urandom_range(32, 126)));
          if ($urandom_range(0, 9) != 0) begin
            push_byte(CH_RPAR);
          end
        end else if (kind < 45) begin
          push_byte(CH_SEMI);
          repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(0, 255)));
        end else if (kind < 58) begin
          push_text("//");
          repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(0, 255)));
        end
        push_end();
      end else begin
        // noise line: raw bytes mixed with the characters that steer the scan
        repeat ($urandom_range(0, 24)) begin
          if ($urandom_range(0, 1) == 0) begin
            c = 8'($urandom_range(0, 255));
          end else begin
            c = specials[$urandom_range(0, specials.len() - 1)];
          end
          push_byte(c);
        end
        push_end();
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // wait until every byte went in and every result came back
    while (raw_line_bytes.size() != 0 || predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transfers over %0d lines, %0d results compared",
             accepted_cnt, lines_done, results_cnt);
    $display("line ends: ok %0d, too long %0d, nested %0d, unclosed %0d; %0d input stalls",
             status_seen[ST_OK], status_seen[ST_TOO_LONG], status_seen[ST_NESTED],
             status_seen[ST_UNCLOSED], hold_stalls);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("timeout with %0d results outstanding", predicted_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
